### rtl/core/first_fit_contiguous_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// first fit slot allocator assertion macros
// concurrent checks on one clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FCSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FCSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fcsa_pkg.sv
// ----------------------------------------------------------------------------
// fcsa_pkg
// shared constants and types of the first fit slot allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcsa_pkg;

  localparam int SLOTS_DEFAULT = 256;

  // field widths
  localparam int RUN_LEN_W = 9;
  localparam int SLOT_W    = 8;
  localparam int LONG_W    = 9;
  localparam int REFUSE_W  = 16;
  localparam int CFG_W     = 9;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 9'd256;

  // action codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // control of the shared run counter
  typedef struct packed {
    logic clear;
    logic step;
    logic free;
  } run_ctl_t;

endpackage

### rtl/core/fcsa_run_unit.sv
// ----------------------------------------------------------------------------
// fcsa_run_unit
// shared free run counter: tracks current and longest free run, flags a fit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcsa_run_unit #(
  parameter int CW = 9,
  parameter int KW = 9
) (
  input  logic               clk,
  input  fcsa_pkg::run_ctl_t ctl,
  input  logic [KW-1:0]      k,
  output logic [CW-1:0]      cur,
  output logic [CW-1:0]      best,
  output logic               hit
);
  import fcsa_pkg::*;

  localparam int XW = (CW > KW) ? CW : KW;

  logic [CW-1:0] inc;

  assign inc = cur + CW'(1);
  assign hit = ctl.free && (XW'(inc) >= XW'(k));

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cur  <= '0;
      best <= '0;
    end else if (ctl.step) begin
      if (ctl.free) begin
        cur <= inc;
        if (inc > best) begin
          best <= inc;
        end
      end else begin
        cur <= '0;
      end
    end
  end

endmodule

### rtl/core/first_fit_contiguous_slot_allocator.sv
// allocate: a fit scan for the first free run of k slots (all managed slots when
// refused), k writes, a run scan and an output step; release: writes from first
// to last plus the run scan and output step; other requests take the run scan
// and output step alone (the scans cover the managed slots only)
// one request at a time; the slot map read one slot per cycle sets the scan
// rate, and a finished request is held at the output step while a result waits
// synchronous reset, then a clearing pass that marks every slot free
`timescale 1ns / 1ps
`include "first_fit_contiguous_slot_allocator_macros.svh"
// ----------------------------------------------------------------------------
// first_fit_contiguous_slot_allocator
// keeps a slot free map, grants first fit runs, frees slot ranges
// ----------------------------------------------------------------------------

module first_fit_contiguous_slot_allocator #(
  parameter int SLOTS = fcsa_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcsa_pkg::PADDR_W-1:0]   paddr,
  input  logic [fcsa_pkg::PDATA_W-1:0]   pwdata,
  output logic [fcsa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [fcsa_pkg::RUN_LEN_W-1:0] run_length,
  input  logic [fcsa_pkg::SLOT_W-1:0]    range_first,
  input  logic [fcsa_pkg::SLOT_W-1:0]    range_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           granted,
  output logic [fcsa_pkg::SLOT_W-1:0]    start_slot,
  output logic [fcsa_pkg::LONG_W-1:0]    longest_free_run,
  output logic [fcsa_pkg::REFUSE_W-1:0]  refusals
);
  import fcsa_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > RUN_LEN_W) ? CW : RUN_LEN_W;
  localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIT,
    ST_WRITE,
    ST_LONG,
    ST_DONE
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      slots_in_use;
  logic [RUN_LEN_W-1:0]  req_k;
  logic [AW-1:0]         wr_idx;
  logic [AW-1:0]         wend;
  logic                  wval;
  logic [CW-1:0]         scan_idx;
  logic                  proc_vld;
  logic [AW-1:0]         proc_idx;
  logic                  res_granted;
  logic [SLOT_W-1:0]     res_start;
  logic [REFUSE_W-1:0]   refusal_count;

  logic                  mem [SLOTS];
  logic                  mem_we;
  logic                  mem_wdata;
  logic [AW-1:0]         rd_addr;
  logic                  rd_data;

  logic [XW-1:0]         cfg_x;
  logic [XW-1:0]         n_x;
  logic                  scanning;
  logic                  issue;
  logic                  scan_end;
  logic                  cfg_wr;
  logic [XW-1:0]         start_x;

  run_ctl_t              run_ctl;
  logic [CW-1:0]         run_cur;
  logic [CW-1:0]         run_best;
  logic                  run_hit;

  // managed count, clamped to the map size
  assign cfg_x = XW'(slots_in_use);
  assign n_x   = (cfg_x > SLOTS_X) ? SLOTS_X : cfg_x;

  assign scanning = (state == ST_FIT) || (state == ST_LONG);
  assign issue    = scanning && (XW'(scan_idx) < n_x);
  assign scan_end = !proc_vld && !issue;
  assign start_x  = XW'(proc_idx) + XW'(1) - XW'(req_k);

  assign in_ready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SLOTS_IN_USE);
  assign prdata   = (paddr[PADDR_W-1] == REG_SLOTS_IN_USE) ? PDATA_W'(slots_in_use) : '0;

  // slot map, 1 = free
  assign mem_we    = (state == ST_CLEAR) || (state == ST_WRITE);
  assign mem_wdata = (state == ST_CLEAR) ? 1'b1 : wval;
  assign rd_addr   = scan_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // counters restart before each scan, longest run held while the result waits
  assign run_ctl.clear = ((state != ST_DONE) && !scanning) || ((state == ST_FIT) && scan_end);
  assign run_ctl.step  = scanning && proc_vld;
  assign run_ctl.free  = rd_data;

  fcsa_run_unit #(
    .CW (CW),
    .KW (RUN_LEN_W)
  ) u_run (
    .clk  (clk),
    .ctl  (run_ctl),
    .k    (req_k),
    .cur  (run_cur),
    .best (run_best),
    .hit  (run_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      slots_in_use  <= SLOTS_IN_USE_RESET;
      wr_idx        <= '0;
      scan_idx      <= '0;
      proc_vld      <= 1'b0;
      refusal_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        slots_in_use <= pwdata[CFG_W-1:0];
      end
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (wr_idx == AW'(SLOTS - 1)) begin
            wr_idx <= '0;
            state  <= ST_IDLE;
          end else begin
            wr_idx <= wr_idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_k    <= run_length;
            scan_idx <= '0;
            proc_vld <= 1'b0;
            if (action == ACT_ALLOC) begin
              res_granted <= 1'b0;
              res_start   <= '0;
              if (run_length != '0) begin
                state <= ST_FIT;
              end else begin
                state <= ST_LONG;
              end
            end else if ((range_first <= range_last) && (XW'(range_last) < n_x)) begin
              wr_idx      <= AW'(XW'(range_first));
              wend        <= AW'(XW'(range_last));
              wval        <= 1'b1;
              res_granted <= 1'b1;
              res_start   <= '0;
              state       <= ST_WRITE;
            end else begin
              res_granted <= 1'b0;
              res_start   <= '0;
              state       <= ST_LONG;
            end
          end
        end
        ST_FIT: begin
          if (proc_vld && run_hit) begin
            // run ends at the slot just read
            wr_idx      <= start_x[AW-1:0];
            wend        <= proc_idx;
            wval        <= 1'b0;
            res_granted <= 1'b1;
            res_start   <= start_x[SLOT_W-1:0];
            proc_vld    <= 1'b0;
            state       <= ST_WRITE;
          end else begin
            proc_vld <= issue;
            proc_idx <= scan_idx[AW-1:0];
            if (issue) begin
              scan_idx <= scan_idx + CW'(1);
            end else if (scan_end) begin
              if (refusal_count != '1) begin
                refusal_count <= refusal_count + REFUSE_W'(1);
              end
              scan_idx <= '0;
              state    <= ST_LONG;
            end
          end
        end
        ST_WRITE: begin
          wr_idx <= wr_idx + AW'(1);
          if (wr_idx == wend) begin
            scan_idx <= '0;
            proc_vld <= 1'b0;
            state    <= ST_LONG;
          end
        end
        ST_LONG: begin
          proc_vld <= issue;
          proc_idx <= scan_idx[AW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (scan_end) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            granted          <= res_granted;
            start_slot       <= res_start;
            longest_free_run <= LONG_W'(run_best);
            refusals         <= refusal_count;
            out_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FCSA_ASSERT_NEXT(a_busy_after_request, clk, rst, in_valid && in_ready, !in_ready, "ready right after request")
  `FCSA_ASSERT_SAME(a_write_in_range, clk, rst, state == ST_WRITE, wr_idx <= wend, "write ran past range end")
  `FCSA_ASSERT_SAME(a_best_covers_cur, clk, rst, 1'b1, run_best >= run_cur, "longest run below current run")
  `FCSA_ASSERT_SAME(a_refusals_monotonic, clk, rst, !$past(rst), refusal_count >= $past(refusal_count), "refusal count went down")

endmodule
